// ----- src/tmrls_pkg.sv -----
// Package for the thrust model RLS estimator: types, constants and codes.
`default_nettype none
package tmrls_pkg;

  localparam int unsigned QueueDepthDef = 128;

  localparam logic [21:0] GravityRst   = 22'd642908;
  localparam logic [15:0] HoverFracRst = 16'd32768;
  localparam logic [30:0] ForgetRst    = 31'd1071594340;
  localparam logic [9:0]  WinLowRst    = 10'd35;
  localparam logic [9:0]  WinHighRst   = 10'd45;

  // One million in Q24.40.
  localparam logic [63:0] CovInit = 64'd1000000 << 40;

  typedef enum logic [1:0] {
    KIND_RECORD   = 2'd0,
    KIND_ESTIMATE = 2'd1,
    KIND_RESEED   = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_GRAVITY   = 3'd0,
    REG_HOVER     = 3'd1,
    REG_FORGET    = 3'd2,
    REG_WIN_LOW   = 3'd3,
    REG_WIN_HIGH  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] time_ms;
    logic [31:0] thrust_value;
    logic [31:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic        updated;
    logic [31:0] slope_estimate;
    logic [15:0] hover_estimate;
    logic [7:0]  queue_count;
  } out_item_t;

  // Divider request and status between the top level and the divider.
  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [63:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- src/tmrls_if.sv -----
// Valid/ready stream interfaces for the item channels and the register write port.
`default_nettype none
interface tmrls_in_if;
  logic                  valid;
  logic                  ready;
  tmrls_pkg::in_item_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tmrls_out_if;
  logic                  valid;
  logic                  ready;
  tmrls_pkg::out_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tmrls_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/tmrls_div.sv -----
// Restoring radix-2 divider, 128-bit dividend by 64-bit divisor, one bit per cycle.
`default_nettype none
module tmrls_div (
  input  wire                  clk,
  input  wire                  rst_n,
  input  tmrls_pkg::div_req_t  req,
  output tmrls_pkg::div_rsp_t  rsp
);
  import tmrls_pkg::*;

  logic         busy_r, busy_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [127:0] num_r, num_nxt;
  logic [127:0] quo_r, quo_nxt;
  logic [63:0]  rem_r, rem_nxt;
  logic [63:0]  den_r;
  logic         done_r, done_nxt;
  logic [64:0]  shifted;
  logic [64:0]  diff;

  // One quotient bit per cycle, most significant first.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, num_r[127]};
    diff     = shifted - {1'b0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd0;
      num_nxt  = req.num;
      quo_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[126:0], 1'b0};
      if (!diff[64]) begin
        rem_nxt = diff[63:0];
        quo_nxt = {quo_r[126:0], 1'b1};
      end else begin
        rem_nxt = shifted[63:0];
        quo_nxt = {quo_r[126:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd127) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign rsp.done = done_r;
  assign rsp.quot = (quo_r[127:64] != '0) ? '1 : quo_r[63:0];

endmodule
`default_nettype wire

// ----- src/thrust_model_rls_estimator_unit.sv -----
// Top level of the thrust model RLS estimator: sample queue, RLS sequencer and outputs.
// A record item writes a sample to the queue and a reseed item reseeds with the seed division;
// an estimate item inspects queue entries and may run an RLS step with two more divisions.
// Every item ends with the hover division. A slope that is not positive skips the hover division.
// One item at a time; a waiting result holds the last step.
// Reset sets queue pointers and registers to their defaults; seeding runs before input is taken.
`default_nettype none
module thrust_model_rls_estimator_unit #(
  parameter int unsigned QUEUE_DEPTH = tmrls_pkg::QueueDepthDef
) (
  input  wire  clk,
  input  wire  rst_n,
  tmrls_in_if.sink    in_ch,
  tmrls_out_if.source out_ch,
  tmrls_cfg_if.sink   cfg_ch
);
  import tmrls_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FW-1:0] DepthF = FW'(QUEUE_DEPTH);

  typedef enum logic [4:0] {
    S_SEED, S_SEED_W, S_IDLE, S_REC, S_RD, S_CHK, S_T1, S_T2, S_T3, S_E1, S_E2,
    S_K1, S_K2, S_K3, S_KW, S_R1, S_R2, S_D1, S_D2, S_D3, S_PW, S_HOV, S_HOV_W,
    S_OUT
  } state_t;

  // Memories for the sample queue.
  logic [31:0] time_mem [QUEUE_DEPTH];
  logic [31:0] thr_mem  [QUEUE_DEPTH];
  logic [31:0] rd_time_r, rd_thr_r;
  logic        wr_en;
  logic [AW-1:0] wr_addr, rd_addr;

  state_t        state_r;
  logic [AW-1:0] head_r;
  logic [FW-1:0] fill_r;
  logic [21:0]   grav_r;
  logic [15:0]   hfrac_r;
  logic [30:0]   rho_r;
  logic [9:0]    wlo_r, whi_r;
  logic signed [31:0] slope_r;
  logic [63:0]   cov_r;
  in_item_t      item_r;
  logic          upd_r;
  logic [15:0]   hov_r;
  out_item_t     out_r;
  logic          out_valid_r;

  // Datapath scratch registers.
  logic [63:0]   tm_r, tsq_r, d_r, kmag_r, rmag_r;
  logic [127:0]  acc_r;
  logic          kneg_r, rneg_r;
  logic signed [63:0] ts_r;

  div_req_t dreq;
  div_rsp_t drsp;

  tmrls_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Queue memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr] <= item_r.time_ms;
      thr_mem[wr_addr]  <= item_r.thrust_value;
    end
    rd_time_r <= time_mem[rd_addr];
    rd_thr_r  <= thr_mem[rd_addr];
  end

  logic [FW:0]   tail_sum;
  logic [AW-1:0] head_inc;
  logic signed [31:0] age;
  logic [AW-1:0] rec_head;
  logic [FW-1:0] rec_fill;

  always_comb begin
    head_inc = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
    if (fill_r >= DepthF) begin
      rec_head = head_inc;
      rec_fill = DepthF - FW'(1);
    end else begin
      rec_head = head_r;
      rec_fill = fill_r;
    end
    tail_sum = {1'b0, FW'(rec_head)} + {1'b0, rec_fill};
    if (tail_sum >= (FW + 1)'(QUEUE_DEPTH)) tail_sum = tail_sum - (FW + 1)'(QUEUE_DEPTH);
    wr_addr = AW'(tail_sum);
    wr_en   = (state_r == S_REC);
    rd_addr = head_r;
    age     = $signed(item_r.time_ms - rd_time_r);
  end

  // 32x32 partial product helper operands, one product per cycle.
  logic [31:0] ma, mb;
  logic [63:0] mprod;
  logic [1:0]  mstep_r;
  assign mprod = ma * mb;

  logic [63:0] x_r, y_r;
  always_comb begin
    case (mstep_r)
      2'd0: begin ma = x_r[31:0];  mb = y_r[31:0];  end
      2'd1: begin ma = x_r[31:0];  mb = y_r[63:32]; end
      2'd2: begin ma = x_r[63:32]; mb = y_r[31:0];  end
      default: begin ma = x_r[63:32]; mb = y_r[63:32]; end
    endcase
  end

  logic [127:0] acc_add;
  always_comb begin
    case (mstep_r)
      2'd0: acc_add = {64'd0, mprod};
      2'd1: acc_add = {32'd0, mprod, 32'd0};
      2'd2: acc_add = {32'd0, mprod, 32'd0};
      default: acc_add = {mprod, 64'd0};
    endcase
  end

  logic [64:0] dsum;
  logic [63:0] e_val, tsm;
  logic signed [63:0] r_val;
  logic [63:0] dmag;
  logic signed [63:0] ns;
  logic [31:0] th_mag;
  always_comb begin
    e_val  = (acc_r[127:122] != '0) ? '1 : acc_r[121:58];
    dsum   = {34'd0, rho_r} + {1'b0, e_val};
    th_mag = rd_thr_r[31] ? (32'd0 - rd_thr_r) : rd_thr_r;
    tsm    = (ts_r < 0 ? (64'd0 - ts_r) : ts_r) >> 24;
    r_val  = {{32{item_r.accel_z[31]}}, item_r.accel_z} -
             (ts_r < 0 ? -$signed(tsm) : $signed(tsm));
    dmag   = (acc_r[127:96] != '0) ? '1 : acc_r[95:32];
    if (dmag > (64'd1 << 33)) dmag = 64'd1 << 33;
    ns = {{32{slope_r[31]}}, slope_r} + ((kneg_r != rneg_r) ? -$signed(dmag) : $signed(dmag));
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = out_r;

  // Marks the power-on seed so that it returns no result.
  logic seeding_r;
  always_ff @(posedge clk) begin
    if (!rst_n) seeding_r <= 1'b1;
    else if (state_r == S_OUT) seeding_r <= 1'b0;
  end

  // Sequencer: state, queue pointers, estimator state and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SEED;
      head_r  <= '0;
      fill_r  <= '0;
      grav_r  <= GravityRst;
      hfrac_r <= HoverFracRst;
      rho_r   <= ForgetRst;
      wlo_r   <= WinLowRst;
      whi_r   <= WinHighRst;
      out_valid_r <= 1'b0;
      dreq    <= '0;
      mstep_r <= '0;
    end else begin
      // The divider starts in the cycle after a state that sets up its operands.
      dreq.start <= (state_r == S_SEED && hfrac_r != '0) || (state_r == S_K3) ||
                    (state_r == S_D3) || (state_r == S_HOV && slope_r > 0);
      // The result register is freed when taken and reloaded when an item finishes, but not for the power-on seed.
      if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) out_valid_r <= !seeding_r;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_ch.valid) begin
        case (reg_idx_t'(cfg_ch.index))
          REG_GRAVITY:  grav_r  <= cfg_ch.data[21:0];
          REG_HOVER:    hfrac_r <= cfg_ch.data[15:0];
          REG_FORGET:   rho_r   <= cfg_ch.data[30:0];
          REG_WIN_LOW:  wlo_r   <= cfg_ch.data[9:0];
          REG_WIN_HIGH: whi_r   <= cfg_ch.data[9:0];
          default: ;
        endcase
      end
      case (state_r)
        S_SEED: begin
          cov_r <= CovInit;
          if (hfrac_r == '0) begin
            slope_r <= (grav_r != '0) ? 32'sh7FFFFFFF : '0;
            state_r <= S_HOV;
          end else begin
            dreq.num   <= {90'd0, grav_r, 16'd0};
            dreq.den   <= {48'd0, hfrac_r};
            state_r    <= S_SEED_W;
          end
        end
        S_SEED_W: if (drsp.done) begin
          slope_r <= (drsp.quot > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : drsp.quot[31:0];
          state_r <= S_HOV;
        end
        S_IDLE: if (in_ch.valid) begin
          item_r <= in_ch.payload;
          upd_r  <= 1'b0;
          case (kind_t'(in_ch.payload.kind))
            KIND_RECORD:   state_r <= S_REC;
            KIND_ESTIMATE: state_r <= S_RD;
            KIND_RESEED:   state_r <= S_SEED;
            default:       state_r <= S_HOV;
          endcase
        end
        S_REC: begin
          head_r  <= rec_head;
          fill_r  <= rec_fill + FW'(1);
          state_r <= S_HOV;
        end
        S_RD: state_r <= (fill_r == '0) ? S_HOV : S_CHK;
        S_CHK: begin
          if (age > $signed({22'd0, whi_r})) begin
            head_r <= head_inc;
            fill_r <= fill_r - FW'(1);
            state_r <= S_RD;
          end else if (age < $signed({22'd0, wlo_r})) begin
            state_r <= S_HOV;
          end else begin
            head_r <= head_inc;
            fill_r <= fill_r - FW'(1);
            upd_r  <= 1'b1;
            kneg_r <= rd_thr_r[31];
            tm_r   <= {32'd0, th_mag};
            ts_r   <= $signed(rd_thr_r) * slope_r;
            state_r <= S_T1;
          end
        end
        // tm*tm fits in 64 bits; then (tm*tm)*P as four partial products.
        S_T1: begin
          tsq_r <= tm_r[31:0] * tm_r[31:0];
          state_r <= S_T2;
        end
        S_T2: begin
          x_r <= tsq_r; y_r <= cov_r; acc_r <= '0; mstep_r <= 2'd0;
          state_r <= S_T3;
        end
        S_T3: begin
          acc_r <= acc_r + acc_add;
          mstep_r <= mstep_r + 2'd1;
          if (mstep_r == 2'd3) state_r <= S_E1;
        end
        S_E1: begin
          if (dsum[64]) d_r <= '1;
          else if (dsum[63:0] == '0) d_r <= 64'd1;
          else d_r <= dsum[63:0];
          state_r <= S_K1;
        end
        S_K1: begin
          x_r <= cov_r; y_r <= tm_r; acc_r <= '0; mstep_r <= 2'd0;
          state_r <= S_K2;
        end
        S_K2: begin
          acc_r <= acc_r + acc_add;
          mstep_r <= mstep_r + 2'd1;
          if (mstep_r == 2'd3) state_r <= S_K3;
        end
        S_K3: begin
          dreq.num   <= acc_r >> 2;
          dreq.den   <= d_r;
          state_r    <= S_KW;
        end
        S_KW: if (drsp.done) begin
          kmag_r <= drsp.quot;
          state_r <= S_R1;
        end
        S_R1: begin
          rmag_r <= (r_val < 0) ? (64'd0 - r_val) : r_val;
          rneg_r <= r_val < 0;
          state_r <= S_R2;
        end
        S_R2: begin
          x_r <= kmag_r; y_r <= rmag_r; acc_r <= '0; mstep_r <= 2'd0;
          state_r <= S_D1;
        end
        S_D1: begin
          acc_r <= acc_r + acc_add;
          mstep_r <= mstep_r + 2'd1;
          if (mstep_r == 2'd3) state_r <= S_D2;
        end
        S_D2: begin
          if (ns > 64'sh7FFFFFFF) slope_r <= 32'sh7FFFFFFF;
          else if (ns < -64'sh80000000) slope_r <= 32'sh80000000;
          else slope_r <= ns[31:0];
          state_r <= S_D3;
        end
        S_D3: begin
          dreq.num   <= {34'd0, cov_r, 30'd0};
          dreq.den   <= d_r;
          state_r    <= S_PW;
        end
        S_PW: if (drsp.done) begin
          cov_r <= drsp.quot;
          state_r <= S_HOV;
        end
        S_HOV: begin
          if (slope_r <= 0) begin
            hov_r <= (slope_r == 0 && grav_r != '0) ? 16'hFFFF : 16'd0;
            state_r <= S_OUT;
          end else begin
            dreq.num   <= {90'd0, grav_r, 16'd0};
            dreq.den   <= {32'd0, slope_r};
            state_r    <= S_HOV_W;
          end
        end
        S_HOV_W: if (drsp.done) begin
          hov_r <= (drsp.quot > 64'hFFFF) ? 16'hFFFF : drsp.quot[15:0];
          state_r <= S_OUT;
        end
        // Wait here until the previous result has been taken.
        S_OUT: if (!out_valid_r || out_ch.ready) begin
          out_r.updated        <= upd_r;
          out_r.slope_estimate <= slope_r;
          out_r.hover_estimate <= hov_r;
          out_r.queue_count    <= 8'(fill_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
